/* rtl/nfba_pkg.sv */
// ----------------------------------------------------------------------------
// Next-fit bitmap allocator package
// Shared widths, configuration register indexes and beat payload types.
// ----------------------------------------------------------------------------
package nfba_pkg;

   // Storage geometry.
   localparam int MAX_BLOCKS = 1024;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W    = $clog2(MAP_WORDS);

   // Field widths.
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_INDEX = 1'b1;

   // Operation codes.
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_MARK     = 1'b1;

   // Request beat.
   typedef struct packed {
      logic             operation;
      logic [IDX_W-1:0] block_index;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [IDX_W-1:0] granted_index;
      logic             out_of_space;
   } rsp_type;

endpackage

/* rtl/nfba_map_ram.sv */
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write and one read port, registered read data. A per-word valid bit
// cleared by reset makes never-written words read back as all free.
// ----------------------------------------------------------------------------
module nfba_map_ram
   import nfba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [WADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0]  rd_data,
   input  logic               wr_en,
   input  logic [WADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0]  wr_data
);

   logic [WORD_W-1:0]    mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_valid_ff;
   logic [WORD_W-1:0]    rd_q_ff;
   logic                 rd_valid_ff;

   // Word storage with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Valid bits: a word reads as zero until it has been written once.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         rd_valid_ff <= word_valid_ff[rd_addr];
         if (wr_en) begin
            word_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

/* rtl/next_fit_bitmap_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// Next-fit bitmap block allocator
// Holds one used bit per block in a 32-bit word memory and hands out free
// blocks starting from a next-fit cursor, wrapping once to first_index.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A mark beat reads the word in the
// cycle in which it is accepted, the mark state writes it back with the bit
// set, and the done state loads the response register. An allocate beat reads
// one bitmap word per cycle through the memory's read port, starting at the
// cursor's word and stopping at the last word below the limit; if that pass
// finds nothing, a second pass runs from first_index. In either case the
// response register is loaded in the done state and the next request can be
// taken in the cycle after it. While the response register still holds an
// unaccepted beat, the sequencer waits in its done state. The bitmap starts
// all free after reset with no clearing pass.
// ----------------------------------------------------------------------------
module next_fit_bitmap_block_allocator_top
   import nfba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   localparam logic [CNT_W-1:0] MAX_BLOCKS_C = CNT_W'(MAX_BLOCKS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   block_count_ff;
   logic [IDX_W-1:0]   first_index_ff;
   logic [CNT_W-1:0]   cursor_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   limit_ff;
   logic [CNT_W-1:0]   from_ff;
   logic               wrap_ff;
   logic [WADDR_W-1:0] chk_word_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [WADDR_W-1:0] rd_addr_in;
   logic [WORD_W-1:0]  rd_data;
   logic               wr_en;
   logic [WADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [BIT_W-1:0]   set_bit;

   logic [CNT_W-1:0]   limit_in;
   logic [CNT_W-1:0]   last_idx;
   logic [WADDR_W-1:0] last_word;
   logic [WORD_W-1:0]  lo_mask;
   logic [WORD_W-1:0]  hi_mask;
   logic [WORD_W-1:0]  free_bits;
   logic               hit;
   logic [BIT_W-1:0]   hit_pos;
   logic [IDX_W-1:0]   hit_idx;
   logic               mark_ok;
   logic               rsp_free;

   // Lowest set bit of a word.
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   nfba_map_ram u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr_in),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Search limit is the block count clamped to the store size.
   assign limit_in = (block_count_ff > MAX_BLOCKS_C) ? MAX_BLOCKS_C : block_count_ff;

   // Word range and edge masks of the current pass.
   assign last_idx  = limit_ff - CNT_W'(1);
   assign last_word = last_idx[IDX_W-1:BIT_W];
   assign lo_mask   = (chk_word_ff == from_ff[IDX_W-1:BIT_W])
                      ? ({WORD_W{1'b1}} << from_ff[BIT_W-1:0]) : {WORD_W{1'b1}};
   assign hi_mask   = (chk_word_ff == last_word)
                      ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_idx[BIT_W-1:0]))
                      : {WORD_W{1'b1}};
   assign free_bits = ~rd_data & lo_mask & hi_mask;
   assign hit       = |free_bits;
   assign hit_pos   = first_set(free_bits);
   assign hit_idx   = {chk_word_ff, hit_pos};

   assign mark_ok  = {1'b0, idx_ff} < MAX_BLOCKS_C;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Memory read address: the marked word on acceptance, the first word of a
   // pass at its start, otherwise the word after the one being checked.
   always_comb begin
      case (state_ff)
         ST_IDLE:  rd_addr_in = req_data.block_index[IDX_W-1:BIT_W];
         ST_START: rd_addr_in = from_ff[IDX_W-1:BIT_W];
         default:  rd_addr_in = chk_word_ff + WADDR_W'(1);
      endcase
   end

   // Write-back of the modified word.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_word_ff;
      set_bit = hit_pos;
      case (state_ff)
         ST_SCAN: begin
            wr_en = hit;
         end
         ST_MARK: begin
            wr_en   = mark_ok;
            set_bit = idx_ff[BIT_W-1:0];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      wr_data = rd_data | (WORD_W'(1) << set_bit);
   end

   // Control sequencer, configuration registers and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         block_count_ff <= MAX_BLOCKS_C;
         first_index_ff <= '0;
         cursor_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         chk_word_ff <= rd_addr_in;

         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
               CSR_FIRST_INDEX: first_index_ff <= csr_wdata[IDX_W-1:0];
               default:         ;
            endcase
         end

         // In the done state a new response replaces the one leaving.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  idx_ff   <= req_data.block_index;
                  limit_ff <= limit_in;
                  from_ff  <= cursor_ff;
                  wrap_ff  <= 1'b0;
                  state_ff <= (req_data.operation == OP_MARK) ? ST_MARK : ST_START;
               end
            end
            ST_START: begin
               if (from_ff >= limit_ff) begin
                  if (wrap_ff) begin
                     res_ff.granted_index <= '0;
                     res_ff.out_of_space  <= 1'b1;
                     state_ff             <= ST_DONE;
                  end else begin
                     from_ff   <= {1'b0, first_index_ff};
                     cursor_ff <= {1'b0, first_index_ff};
                     wrap_ff   <= 1'b1;
                  end
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  cursor_ff            <= {1'b0, hit_idx} + CNT_W'(1);
                  res_ff.granted_index <= hit_idx;
                  res_ff.out_of_space  <= 1'b0;
                  state_ff             <= ST_DONE;
               end else if (chk_word_ff == last_word) begin
                  // Pass exhausted: an empty range sends the start state on.
                  from_ff  <= limit_ff;
                  state_ff <= ST_START;
               end
            end
            ST_MARK: begin
               res_ff.granted_index <= '0;
               res_ff.out_of_space  <= 1'b0;
               state_ff             <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/next_fit_bitmap_block_allocator_top_test.sv */
// ----------------------------------------------------------------------------
// Next-fit bitmap block allocator regression
// Drives allocate and mark beats into the allocator and predicts every
// response with a bit-level model of the used map, the next-fit cursor and
// the two settings. Responses are checked field by field in order. The run
// covers directed corner cases, random windows of the block space under
// several settings, a long response hold-off and an idle-free stream.
// ----------------------------------------------------------------------------
module next_fit_bitmap_block_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nfba_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 80;
   localparam int WINDOW_PHASES = 11;
   localparam int PHASE_BEATS   = 90;

   // Block ports; the ones driven here are known from time zero.
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BLOCK_COUNT;
   logic [CNT_W-1:0]     csr_wdata = '0;

   // Allocator state as the testbench sees it.
   bit [MAX_BLOCKS-1:0]  used_blocks         = '0;
   int unsigned          scan_cursor         = 0;
   logic [CNT_W-1:0]     block_limit_setting = CNT_W'(1024);
   logic [IDX_W-1:0]     wrap_index_setting  = '0;
   rsp_type              pending_grants[$];

   int unsigned          mismatches        = 0;
   int unsigned          cycle_count       = 0;
   bit                   idling_on         = 1'b1;
   int unsigned          hold_off_request  = 0;
   int unsigned          holds_seen        = 0;
   int unsigned          hold_left         = 0;
   int unsigned          stall_left        = 0;

   next_fit_bitmap_block_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Lowest free block in [from, upper), or -1 when there is none.
   function automatic int first_free_block(input int unsigned from, input int unsigned upper);
      for (int unsigned pos = from; pos < upper; pos++) begin
         if (!used_blocks[pos]) return int'(pos);
      end
      return -1;
   endfunction

   // Applies one accepted beat to the map and cursor and returns its response.
   function automatic rsp_type predict_grant(input req_type beat);
      rsp_type     outcome;
      int unsigned upper;
      int          found;
      outcome = '0;
      if (beat.operation == OP_MARK) begin
         used_blocks[beat.block_index] = 1'b1;
         return outcome;
      end
      upper = int'(block_limit_setting);
      if (upper > MAX_BLOCKS) begin
         upper = MAX_BLOCKS;
      end
      found = first_free_block(scan_cursor, upper);
      // Nothing above the cursor: wrap to the first index and scan once more.
      if (found < 0) begin
         scan_cursor = int'(wrap_index_setting);
         found = first_free_block(scan_cursor, upper);
      end
      if (found < 0) begin
         outcome.out_of_space = 1'b1;
      end else begin
         used_blocks[found]    = 1'b1;
         scan_cursor           = found + 1;
         outcome.granted_index = IDX_W'(found);
      end
      return outcome;
   endfunction

   function automatic void note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
   endfunction

   // Offers one beat, after an optional idle burst, and returns at its acceptance.
   // Valid is left high so that a following beat can be offered back to back.
   task automatic send_request(input logic op, input logic [IDX_W-1:0] idx);
      req_type beat;
      int      gap;
      beat.operation   = op;
      beat.block_index = idx;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_grants.push_back(predict_grant(beat));
   endtask

   // Must follow the last send_request with no time in between.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] which,
                                input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (which == CSR_BLOCK_COUNT) begin
         block_limit_setting = value;
      end else begin
         wrap_index_setting = value[IDX_W-1:0];
      end
   endtask

   // Response checker: every accepted beat against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_grants.size() == 0) begin
            note_mismatch("unexpected response beat", -1, int'(rsp_data));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.granted_index !== want.granted_index) begin
               note_mismatch("granted_index", int'(want.granted_index),
                             int'(rsp_data.granted_index));
            end
            if (rsp_data.out_of_space !== want.out_of_space) begin
               note_mismatch("out_of_space", int'(want.out_of_space),
                             int'(rsp_data.out_of_space));
            end
         end
      end
   end

   // Response ready: a counted long hold-off on request, otherwise short random stalls while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  <= 0;
         stall_left <= 0;
      end else if (holds_seen != hold_off_request) begin
         holds_seen <= hold_off_request;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("next_fit_bitmap_block_allocator_top regression: fail");
         $finish;
      end
   end

   // Corner cases: wrap, exhaustion, clamped and zero block count, first index
   // above the block count, marks of used blocks and of blocks past the count.
   task automatic test_directed_cases();
      send_request(OP_ALLOCATE, '0);
      send_request(OP_ALLOCATE, IDX_W'(1023));
      send_request(OP_MARK, IDX_W'(2));
      send_request(OP_ALLOCATE, IDX_W'(341));
      send_request(OP_MARK, IDX_W'(1023));
      send_request(OP_MARK, IDX_W'(3));
      send_request(OP_MARK, '0);
      drain_and_settle();
      write_setting(CSR_BLOCK_COUNT, CNT_W'(6));
      write_setting(CSR_FIRST_INDEX, CNT_W'(1));
      send_request(OP_ALLOCATE, IDX_W'(682));
      send_request(OP_ALLOCATE, '0);
      send_request(OP_ALLOCATE, '0);
      send_request(OP_MARK, IDX_W'(900));
      drain_and_settle();
      write_setting(CSR_BLOCK_COUNT, CNT_W'(2047));
      send_request(OP_ALLOCATE, '0);
      drain_and_settle();
      write_setting(CSR_BLOCK_COUNT, '0);
      send_request(OP_ALLOCATE, '0);
      drain_and_settle();
      write_setting(CSR_BLOCK_COUNT, CNT_W'(10));
      write_setting(CSR_FIRST_INDEX, CNT_W'(1023));
      repeat (5) send_request(OP_ALLOCATE, '0);
      drain_and_settle();
      write_setting(CSR_BLOCK_COUNT, CNT_W'(1024));
      send_request(OP_ALLOCATE, '0);
      drain_and_settle();
      write_setting(CSR_FIRST_INDEX, '0);
      send_request(OP_ALLOCATE, '0);
      drain_and_settle();
      write_setting(CSR_BLOCK_COUNT, CNT_W'(1));
      send_request(OP_ALLOCATE, '0);
      send_request(OP_MARK, IDX_W'(5));
      drain_and_settle();
   endtask

   // Random windows of the block space, mostly small so they fill and wrap,
   // plus the whole store, a clamped count and a zero count.
   task automatic test_random_windows();
      int unsigned base;
      int unsigned upper;
      int unsigned beats;
      logic        op;
      logic [IDX_W-1:0] idx;
      for (int phase = 0; phase < WINDOW_PHASES; phase++) begin
         beats = PHASE_BEATS;
         case (phase)
            3: begin
               base  = 0;
               upper = 1024;
            end
            6: begin
               base  = $urandom_range(0, 1023);
               upper = $urandom_range(1025, 2047);
            end
            8: begin
               base  = $urandom_range(0, 1023);
               upper = 0;
               beats = 30;
            end
            default: begin
               base  = $urandom_range(0, 1000);
               upper = base + $urandom_range(1, 48);
            end
         endcase
         write_setting(CSR_BLOCK_COUNT, CNT_W'(upper));
         // Now and then the first index lands anywhere, above the count too.
         if ($urandom_range(0, 7) == 0) begin
            write_setting(CSR_FIRST_INDEX, CNT_W'($urandom_range(0, 1023)));
         end else begin
            write_setting(CSR_FIRST_INDEX, CNT_W'(base));
         end
         idling_on <= ($urandom_range(0, 3) != 0);
         for (int unsigned n = 0; n < beats; n++) begin
            op  = ($urandom_range(0, 3) == 0) ? OP_MARK : OP_ALLOCATE;
            idx = IDX_W'($urandom_range(0, 1023));
            if (op == OP_MARK && $urandom_range(0, 1) == 0) begin
               idx = IDX_W'(base + $urandom_range(0, 56));
            end
            send_request(op, idx);
         end
         drain_and_settle();
      end
   endtask

   // The receiver holds off for a long stretch while beats keep coming, so
   // the block fills and stops taking requests.
   task automatic test_output_backpressure();
      write_setting(CSR_BLOCK_COUNT, CNT_W'(1024));
      write_setting(CSR_FIRST_INDEX, CNT_W'($urandom_range(0, 1023)));
      idling_on        <= 1'b0;
      hold_off_request <= hold_off_request + 1;
      for (int n = 0; n < 40; n++) begin
         send_request(($urandom_range(0, 4) == 0) ? OP_MARK : OP_ALLOCATE,
                      IDX_W'($urandom_range(0, 1023)));
      end
      drain_and_settle();
   endtask

   // Back-to-back beats with no idling on either side.
   task automatic test_steady_stream();
      write_setting(CSR_BLOCK_COUNT, CNT_W'($urandom_range(900, 1024)));
      write_setting(CSR_FIRST_INDEX, '0);
      idling_on <= 1'b0;
      for (int n = 0; n < 120; n++) begin
         send_request(($urandom_range(0, 3) == 0) ? OP_MARK : OP_ALLOCATE,
                      IDX_W'($urandom_range(0, 1023)));
      end
      drain_and_settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_windows();
      test_output_backpressure();
      test_steady_stream();
      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("next_fit_bitmap_block_allocator_top regression: pass");
      end else begin
         $display("next_fit_bitmap_block_allocator_top regression: fail");
      end
      $finish;
   end

endmodule
